### rtl/bma_pkg.sv
// Package with the shared types, codes and sizes of the buddy allocator.
`timescale 1ns / 1ps
package bma_pkg;

    localparam int MEM_BYTES  = 1024;
    localparam int MIN_BLOCK  = 1;
    localparam int NODE_COUNT = 2 * (MEM_BYTES / MIN_BLOCK) - 1;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int SZ_W       = $clog2(MEM_BYTES) + 1;
    localparam int INFO_W     = 27;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_FREE   = 2'd1,
        ST_ALLOC  = 2'd2,
        ST_SPLIT  = 2'd3
    } node_st_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_MISS    = 2'd1;
    localparam logic [1:0] RES_INVALID = 2'd2;

    typedef struct packed {
        logic        command;
        logic [10:0] request_size;
        logic [15:0] owner_id;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_start;
        logic [10:0] block_size;
        logic [10:0] freed_request_size;
    } out_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_LEAF_INIT,
        OP_DESCEND,
        OP_ADVANCE,
        OP_SPLIT_A,
        OP_SPLIT_B,
        OP_ALLOC,
        OP_FREE_MARK,
        OP_SIB_READ,
        OP_MERGE_A,
        OP_MERGE_B,
        OP_MERGE_C,
        OP_DONE_FREE,
        OP_FAIL,
        OP_INVALID
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF_INIT,
        S_LEAF_RD,
        S_LEAF_CHK,
        S_ADVANCE,
        S_SPLIT_CHK,
        S_SPLIT_A,
        S_SPLIT_B,
        S_ALLOC,
        S_FREE_MARK,
        S_MRG_TOP,
        S_SIB_RD,
        S_SIB_CHK,
        S_MERGE_A,
        S_MERGE_B,
        S_MERGE_C,
        S_DONE_FREE,
        S_FAIL,
        S_INVALID
    } state_t;

    typedef struct packed {
        logic clr_done;
        logic invalid;
        logic is_free_cmd;
        logic descend;
        logic fit;
        logic hit;
        logic adv_end;
        logic split_more;
        logic at_root;
        logic sib_free;
    } dp_status_t;

endpackage

### rtl/bma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bma_ctrl.sv
// Controller state machine that sequences the tree walk, split and merge steps.
`timescale 1ns / 1ps
module bma_ctrl
    import bma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t stat,
    output op_t        op,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:     state_next = stat.clr_done ? S_IDLE : S_CLEAR;
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = stat.invalid ? S_INVALID : S_LEAF_INIT;
                end
            end
            S_LEAF_INIT: state_next = S_LEAF_RD;
            S_LEAF_RD:   state_next = S_LEAF_CHK;
            S_LEAF_CHK:
            begin
                if (stat.descend)
                begin
                    state_next = S_LEAF_RD;
                end
                else if (!stat.is_free_cmd && stat.fit)
                begin
                    state_next = S_SPLIT_CHK;
                end
                else if (stat.is_free_cmd && stat.hit)
                begin
                    state_next = S_FREE_MARK;
                end
                else
                begin
                    state_next = S_ADVANCE;
                end
            end
            S_ADVANCE:   state_next = stat.adv_end ? S_FAIL : S_LEAF_INIT;
            S_SPLIT_CHK: state_next = stat.split_more ? S_SPLIT_A : S_ALLOC;
            S_SPLIT_A:   state_next = S_SPLIT_B;
            S_SPLIT_B:   state_next = S_SPLIT_CHK;
            S_FREE_MARK: state_next = S_MRG_TOP;
            S_MRG_TOP:   state_next = stat.at_root ? S_DONE_FREE : S_SIB_RD;
            S_SIB_RD:    state_next = S_SIB_CHK;
            S_SIB_CHK:   state_next = stat.sib_free ? S_MERGE_A : S_DONE_FREE;
            S_MERGE_A:   state_next = S_MERGE_B;
            S_MERGE_B:   state_next = S_MERGE_C;
            S_MERGE_C:   state_next = S_MRG_TOP;
            S_ALLOC,
            S_DONE_FREE,
            S_FAIL,
            S_INVALID:   state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:     op = OP_CLEAR;
            S_IDLE:      op = start ? OP_LOAD : OP_NONE;
            S_LEAF_INIT: op = OP_LEAF_INIT;
            S_LEAF_CHK:  op = stat.descend ? OP_DESCEND : OP_NONE;
            S_ADVANCE:   op = OP_ADVANCE;
            S_SPLIT_A:   op = OP_SPLIT_A;
            S_SPLIT_B:   op = OP_SPLIT_B;
            S_ALLOC:     op = OP_ALLOC;
            S_FREE_MARK: op = OP_FREE_MARK;
            S_SIB_RD:    op = OP_SIB_READ;
            S_MERGE_A:   op = OP_MERGE_A;
            S_MERGE_B:   op = OP_MERGE_B;
            S_MERGE_C:   op = OP_MERGE_C;
            S_DONE_FREE: op = OP_DONE_FREE;
            S_FAIL:      op = OP_FAIL;
            S_INVALID:   op = OP_INVALID;
            default:     op = OP_NONE;
        endcase
    end

endmodule

### rtl/bma_datapath.sv
// Datapath with the node tables, walk registers and result register.
`timescale 1ns / 1ps
module bma_datapath
    import bma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    input  in_word_t   item,
    output dp_status_t stat,
    output out_word_t  result,
    output logic       done
);

    in_word_t             in_reg;
    logic [IDX_W-1:0]     i_reg;
    logic [SZ_W-1:0]      s_reg;
    logic [SZ_W-1:0]      z_reg;
    logic [SZ_W-1:0]      addr_reg;
    logic [IDX_W-1:0]     clr_reg;
    logic [10:0]          freed_reg;
    logic                 done_reg;
    out_word_t            result_reg;

    logic [SZ_W-1:0]      half;
    logic [SZ_W-1:0]      s_end;
    logic [IDX_W:0]       left_wide;
    logic [IDX_W:0]       right_wide;
    logic [IDX_W-1:0]     sib;
    logic [IDX_W-1:0]     parent;
    logic [IDX_W-1:0]     raddr;
    logic                 st_we;
    logic [IDX_W-1:0]     st_waddr;
    logic [1:0]           st_wdata;
    logic [1:0]           st_rdata;
    logic [INFO_W-1:0]    info_rdata;
    logic                 info_we;

    assign half       = z_reg >> 1;
    assign s_end      = s_reg + z_reg;
    assign left_wide  = {i_reg, 1'b1};
    assign right_wide = {i_reg, 1'b0} + (IDX_W+1)'(2);
    assign sib        = i_reg[0] ? (i_reg + IDX_W'(1)) : (i_reg - IDX_W'(1));
    assign parent     = (i_reg - IDX_W'(1)) >> 1;
    assign raddr      = (op == OP_SIB_READ) ? sib : i_reg;
    assign info_we    = (op == OP_ALLOC);

    always_comb
    begin
        st_we    = 1'b1;
        st_waddr = i_reg;
        st_wdata = ST_UNUSED;
        case (op)
            OP_CLEAR:
            begin
                st_waddr = clr_reg;
                st_wdata = (clr_reg == '0) ? ST_FREE : ST_UNUSED;
            end
            OP_SPLIT_A:   st_wdata = ST_SPLIT;
            OP_SPLIT_B:
            begin
                st_waddr = right_wide[IDX_W-1:0];
                st_wdata = ST_FREE;
            end
            OP_ALLOC:     st_wdata = ST_ALLOC;
            OP_FREE_MARK: st_wdata = ST_FREE;
            OP_MERGE_A:   st_wdata = ST_UNUSED;
            OP_MERGE_B:   st_waddr = sib;
            OP_MERGE_C:
            begin
                st_waddr = parent;
                st_wdata = ST_FREE;
            end
            default:      st_we = 1'b0;
        endcase
    end

    bma_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    bma_ram #(.WIDTH(INFO_W), .DEPTH(NODE_COUNT)) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (i_reg),
        .wdata ({in_reg.owner_id, in_reg.request_size}),
        .raddr (raddr),
        .rdata (info_rdata)
    );

    always_comb
    begin
        stat.clr_done    = (clr_reg == IDX_W'(NODE_COUNT - 1));
        stat.invalid     = (item.owner_id == '0)
                         || (item.command == CMD_ALLOC
                             && (item.request_size == '0
                                 || SZ_W'(item.request_size) > SZ_W'(MEM_BYTES)));
        stat.is_free_cmd = (in_reg.command == CMD_FREE);
        stat.descend     = (st_rdata == ST_SPLIT) && (z_reg > SZ_W'(MIN_BLOCK));
        stat.fit         = (st_rdata == ST_FREE) && (z_reg >= SZ_W'(in_reg.request_size));
        stat.hit         = (st_rdata == ST_ALLOC)
                         && (info_rdata[INFO_W-1:11] == in_reg.owner_id);
        stat.adv_end     = (s_end >= SZ_W'(MEM_BYTES));
        stat.split_more  = (half >= SZ_W'(in_reg.request_size))
                         && (half >= SZ_W'(MIN_BLOCK));
        stat.at_root     = (i_reg == '0);
        stat.sib_free    = (st_rdata == ST_FREE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_CLEAR && clr_reg != IDX_W'(NODE_COUNT - 1))
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            done_reg <= (op == OP_ALLOC) || (op == OP_DONE_FREE)
                     || (op == OP_FAIL) || (op == OP_INVALID);
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                in_reg   <= item;
                addr_reg <= '0;
            end
            OP_LEAF_INIT:
            begin
                i_reg <= '0;
                s_reg <= '0;
                z_reg <= SZ_W'(MEM_BYTES);
            end
            OP_DESCEND:
            begin
                if (addr_reg >= s_reg + half)
                begin
                    i_reg <= right_wide[IDX_W-1:0];
                    s_reg <= s_reg + half;
                end
                else
                begin
                    i_reg <= left_wide[IDX_W-1:0];
                end
                z_reg <= half;
            end
            OP_ADVANCE:   addr_reg <= s_end;
            OP_SPLIT_B:
            begin
                i_reg <= left_wide[IDX_W-1:0];
                z_reg <= half;
            end
            OP_FREE_MARK: freed_reg <= info_rdata[10:0];
            OP_MERGE_C:   i_reg <= parent;
            OP_ALLOC:
            begin
                result_reg.status             <= RES_OK;
                result_reg.block_start        <= s_reg[9:0];
                result_reg.block_size         <= z_reg[10:0];
                result_reg.freed_request_size <= '0;
            end
            OP_DONE_FREE:
            begin
                result_reg.status             <= RES_OK;
                result_reg.block_start        <= s_reg[9:0];
                result_reg.block_size         <= z_reg[10:0];
                result_reg.freed_request_size <= freed_reg;
            end
            OP_FAIL, OP_INVALID:
            begin
                result_reg.status             <= (op == OP_FAIL) ? RES_MISS : RES_INVALID;
                result_reg.block_start        <= '0;
                result_reg.block_size         <= '0;
                result_reg.freed_request_size <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;
    assign done   = done_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.status != RES_OK |->
            result_reg.block_size == '0 && result_reg.block_start == '0)
        else $error("failed result carries a nonzero block");

    a_descend_halves: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_DESCEND |=> z_reg == ($past(z_reg) >> 1))
        else $error("descend did not halve the block size");

    a_alloc_fits: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.status == RES_OK && in_reg.command == CMD_ALLOC |->
            result_reg.block_size >= in_reg.request_size)
        else $error("allocated block smaller than the request");

endmodule

### rtl/buddy_memory_allocator_unit.sv
// Top level of the buddy allocator: controller and datapath.
// A rejected word is answered without a tree walk; the longest failed scan visits all 1024
// one-byte leaves. The work on a word is made of tree levels walked, leaves advanced,
// split steps and merge steps. One word is in work at a time.
// The result is shown for one cycle with done high; the receiver cannot stall.
// After reset a clearing pass initializes the node table, with busy high.
`timescale 1ns / 1ps
module buddy_memory_allocator_unit
    import bma_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  item,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    op_t        op;
    dp_status_t stat;

    bma_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    bma_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .item   (item),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule
